// ===== hw/rtl/tpg_pkg.sv =====
// Types and constants shared by the two-peak profile generator.
// No dependencies.
`default_nettype none

package tpg_pkg;

    localparam int unsigned MAX_PROFILE_SAMPLES = 65535;
    localparam int unsigned DATA_W  = 16;
    localparam int unsigned ACC_W   = 40;
    localparam int unsigned DIV_W   = 33;
    localparam int unsigned CNT_W   = 6;

    typedef logic [2:0] tpg_reg_idx_t;
    typedef logic [2:0] tpg_seg_t;

    localparam tpg_reg_idx_t REG_SHAPE     = 3'd0;
    localparam tpg_reg_idx_t REG_LEAD      = 3'd1;
    localparam tpg_reg_idx_t REG_P1_LEN    = 3'd2;
    localparam tpg_reg_idx_t REG_P1_HGT    = 3'd3;
    localparam tpg_reg_idx_t REG_P2_LEN    = 3'd4;
    localparam tpg_reg_idx_t REG_P2_HGT    = 3'd5;
    localparam tpg_reg_idx_t REG_OFFSET    = 3'd6;
    localparam tpg_reg_idx_t REG_INTERVAL  = 3'd7;

    localparam tpg_seg_t SEG_LEAD    = 3'd0;
    localparam tpg_seg_t SEG_P1_UP   = 3'd1;
    localparam tpg_seg_t SEG_P1_DOWN = 3'd2;
    localparam tpg_seg_t SEG_P2_UP   = 3'd3;
    localparam tpg_seg_t SEG_P2_DOWN = 3'd4;
    localparam tpg_seg_t SEG_REST    = 3'd5;

    localparam logic SHAPE_SQUARE = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEG,
        ST_DIV,
        ST_STEP,
        ST_ACC,
        ST_MAG,
        ST_OUT
    } tpg_state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/two_peak_profile_generator.sv =====
// Two-peak profile generator: one profile sample per input request.
// Depends on tpg_pkg (types, segment and register codes).
//
//   channel | dir | handshake          | payload
//   cfg     | in  | cfg_write          | cfg_index, cfg_data[15:0]
//   s       | in  | s_tvalid/s_tready  | s_tdata[0] restart
//   m       | out | m_tvalid/m_tready  | m_tdata sample_word, m_tuser segment, m_tlast
//
// Square-mode samples and samples outside a peak pass only the SEG and OUT states.
// Triangle ramp samples also pass the bit-serial 33-bit step divider (DIV), then STEP, ACC and MAG.
// s_tready is high only while the sequencer is idle; a finished sample waits in
// the output register and stalls the sequencer only if the previous one is still held.
// Reset is asynchronous; no clearing pass.
`default_nettype none

module two_peak_profile_generator (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_write,
    input  wire tpg_pkg::tpg_reg_idx_t cfg_index,
    input  wire logic [15:0]          cfg_data,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [7:0]           s_tdata,   // [0] restart
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [15:0]               m_tdata,   // [15:0] sample_word
    output logic [2:0]                m_tuser,   // [2:0] segment
    output logic                      m_tlast    // period_end
);
    import tpg_pkg::*;

    // configuration
    logic                shape_reg;
    logic [DATA_W-1:0]   lead_reg, p1_len_reg, p1_hgt_reg, p2_len_reg, p2_hgt_reg;
    logic [DATA_W-1:0]   offset_reg, interval_reg;

    // sequencer and datapath
    tpg_state_t          state_reg, state_next;
    logic [DATA_W-1:0]   position_reg, position_next;
    logic [DATA_W-1:0]   x_reg, x_next;
    tpg_seg_t            seg_reg, seg_next;
    logic                end_reg, end_next;
    logic [DATA_W-1:0]   word_reg, word_next;
    logic                neg_reg, neg_next;
    logic [ACC_W-1:0]    acc_reg, acc_next;
    logic [ACC_W-1:0]    step_reg, step_next;
    logic [DIV_W-1:0]    dq_reg, dq_next;
    logic [DATA_W:0]     rem_reg, rem_next;
    logic [DATA_W-1:0]   divisor_reg, divisor_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]   out_word_reg, out_word_next;
    tpg_seg_t            out_seg_reg, out_seg_next;
    logic                out_end_reg, out_end_next;

    // segment decode
    logic [DATA_W-1:0]   len_cap, len_eff;
    logic [DATA_W+1:0]   x_w, lead_w, b1, b2, b3, b4;
    logic                in_lead, in_p1, in_p2, in_ramp;
    tpg_seg_t            seg_sq, seg_tri;
    logic [ACC_W-1:0]    off_fx;
    logic [DATA_W-1:0]   h_sel, h_mag;
    logic                end_c;

    // shared arithmetic
    logic [DATA_W:0]     trial;
    logic                trial_ge;
    logic [ACC_W-1:0]    quot_w, acc_mag;
    logic                out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shape_reg    <= 1'b0;
            lead_reg     <= '0;
            p1_len_reg   <= '0;
            p1_hgt_reg   <= '0;
            p2_len_reg   <= '0;
            p2_hgt_reg   <= '0;
            offset_reg   <= '0;
            interval_reg <= 16'd1;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_SHAPE:    shape_reg    <= cfg_data[0];
                REG_LEAD:     lead_reg     <= cfg_data;
                REG_P1_LEN:   p1_len_reg   <= cfg_data;
                REG_P1_HGT:   p1_hgt_reg   <= cfg_data;
                REG_P2_LEN:   p2_len_reg   <= cfg_data;
                REG_P2_HGT:   p2_hgt_reg   <= cfg_data;
                REG_OFFSET:   offset_reg   <= cfg_data;
                REG_INTERVAL: interval_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    // segment bounds, computed wide
    always_comb
    begin
        len_cap = ({4'b0, interval_reg} > 20'(MAX_PROFILE_SAMPLES))
                  ? 16'(MAX_PROFILE_SAMPLES) : interval_reg;
        len_eff = (len_cap == '0) ? 16'd1 : len_cap;
        x_w     = {2'b0, x_reg};
        lead_w  = {2'b0, lead_reg};
        b1      = lead_w + {3'b0, p1_len_reg[DATA_W-1:1]};
        b2      = lead_w + {2'b0, p1_len_reg};
        b3      = b2 + {3'b0, p2_len_reg[DATA_W-1:1]};
        b4      = b2 + {2'b0, p2_len_reg};
        in_lead = x_w < lead_w;
        in_p1   = x_w < b2;
        in_p2   = x_w < b4;
        in_ramp = !in_lead && in_p2;

        if (in_lead)
            seg_sq = SEG_LEAD;
        else if (in_p1)
            seg_sq = SEG_P1_UP;
        else if (in_p2)
            seg_sq = SEG_P2_UP;
        else
            seg_sq = SEG_REST;

        if (in_lead)
            seg_tri = SEG_LEAD;
        else if (!in_p2)
            seg_tri = SEG_REST;
        else if (in_p1)
            seg_tri = (x_w < b1) ? SEG_P1_UP : SEG_P1_DOWN;
        else
            seg_tri = (x_w < b3) ? SEG_P2_UP : SEG_P2_DOWN;

        off_fx = {{(ACC_W-DATA_W-16){offset_reg[DATA_W-1]}}, offset_reg, 16'b0};
        h_sel  = in_p1 ? p1_hgt_reg : p2_hgt_reg;
        h_mag  = h_sel[DATA_W-1] ? 16'(~h_sel + 16'd1) : h_sel;
        end_c  = ({1'b0, x_reg} + 17'd1) >= {1'b0, len_eff};

        trial    = {rem_reg[DATA_W-1:0], dq_reg[DIV_W-1]};
        trial_ge = trial >= {1'b0, divisor_reg};
        quot_w   = {{(ACC_W-DIV_W){1'b0}}, dq_reg};
        acc_mag  = acc_reg[ACC_W-1] ? (~acc_reg + 40'd1) : acc_reg;
        out_free = !out_valid_reg || m_tready;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (s_tvalid)
                    state_next = ST_SEG;
            ST_SEG:
                if (shape_reg != SHAPE_SQUARE && in_ramp)
                    state_next = ST_DIV;
                else
                    state_next = ST_OUT;
            ST_DIV:
                if (cnt_reg == '0)
                    state_next = ST_STEP;
            ST_STEP:
                state_next = ST_ACC;
            ST_ACC:
                state_next = ST_MAG;
            ST_MAG:
                state_next = ST_OUT;
            ST_OUT:
                if (out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        s_tready       = (state_reg == ST_IDLE);
        position_next  = position_reg;
        x_next         = x_reg;
        seg_next       = seg_reg;
        end_next       = end_reg;
        word_next      = word_reg;
        neg_next       = neg_reg;
        acc_next       = acc_reg;
        step_next      = step_reg;
        dq_next        = dq_reg;
        rem_next       = rem_reg;
        divisor_next   = divisor_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_word_next  = out_word_reg;
        out_seg_next   = out_seg_reg;
        out_end_next   = out_end_reg;

        case (state_reg)
            ST_IDLE:
                if (s_tvalid)
                    x_next = s_tdata[0] ? '0 : position_reg;
            ST_SEG:
            begin
                end_next      = end_c;
                position_next = end_c ? '0 : 16'(x_reg + 16'd1);
                neg_next      = 1'b0;
                if (shape_reg == SHAPE_SQUARE)
                begin
                    seg_next = seg_sq;
                    acc_next = off_fx;
                    if (seg_sq == SEG_P1_UP)
                        word_next = 16'(offset_reg + p1_hgt_reg);
                    else if (seg_sq == SEG_P2_UP)
                        word_next = 16'(offset_reg + p2_hgt_reg);
                    else
                        word_next = offset_reg;
                end
                else
                begin
                    seg_next = seg_tri;
                    if (!in_ramp || x_reg == '0)
                        acc_next = off_fx;
                    word_next    = offset_reg;
                    neg_next     = in_ramp && h_sel[DATA_W-1];
                    dq_next      = {h_mag, 17'b0};
                    rem_next     = '0;
                    divisor_next = in_p1 ? p1_len_reg : p2_len_reg;
                    cnt_next     = CNT_W'(DIV_W - 1);
                end
            end
            ST_DIV:
            begin
                rem_next = trial_ge ? (trial - {1'b0, divisor_reg}) : trial;
                dq_next  = {dq_reg[DIV_W-2:0], trial_ge};
                cnt_next = cnt_reg - 1'b1;
            end
            ST_STEP:
                step_next = neg_reg ? (~quot_w + 40'd1) : quot_w;
            ST_ACC:
                if (seg_reg == SEG_P1_UP || seg_reg == SEG_P2_UP)
                    acc_next = acc_reg + step_reg;
                else
                    acc_next = acc_reg - step_reg;
            ST_MAG:
            begin
                neg_next  = acc_reg[ACC_W-1];
                word_next = acc_mag[31:16];
            end
            ST_OUT:
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_word_next  = neg_reg ? 16'(~word_reg + 16'd1) : word_reg;
                    out_seg_next   = seg_reg;
                    out_end_next   = end_reg;
                end
            default:
                ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            position_reg  <= '0;
            acc_reg       <= '0;
            step_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            position_reg  <= position_next;
            acc_reg       <= acc_next;
            step_reg      <= step_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        seg_reg      <= seg_next;
        end_reg      <= end_next;
        word_reg     <= word_next;
        neg_reg      <= neg_next;
        dq_reg       <= dq_next;
        rem_reg      <= rem_next;
        divisor_reg  <= divisor_next;
        out_word_reg <= out_word_next;
        out_seg_reg  <= out_seg_next;
        out_end_reg  <= out_end_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_word_reg;
    assign m_tuser  = out_seg_reg;
    assign m_tlast  = out_end_reg;

`ifndef SYNTH
    a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("sequencer took a second request");

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> cnt_reg <= CNT_W'(DIV_W - 1))
        else $error("divider count out of range");

    a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == ST_OUT))
        else $error("result appeared outside the output step");

    a_seg_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser <= SEG_REST)
        else $error("bad segment code");
`endif

endmodule

`default_nettype wire
